### hdl/bmcd_pkg.sv
`timescale 1ns / 1ps

package bmcd_pkg;

    localparam int COLOR_W = 32;
    localparam int CNT_W   = 7;

    localparam logic [CNT_W-1:0]   CNT_MAX    = 7'd127;
    localparam logic [CNT_W-1:0]   CNT_NONE   = 7'd0;
    localparam logic [CNT_W-1:0]   CNT_ONE    = 7'd1;
    localparam logic [COLOR_W-1:0] COLOR_NONE = 32'hFFFF_FFFF;

    // Pixel broadcast to every cell of the table.
    typedef struct packed {
        logic               en;
        logic [COLOR_W-1:0] color;
        logic               hit;
    } t_bcast;

    // Running maximum handed from cell to cell during the mode search.
    typedef struct packed {
        logic               go;
        logic [CNT_W-1:0]   cnt;
        logic [COLOR_W-1:0] color;
    } t_scan;

endpackage

### hdl/bmcd_cell.sv
`timescale 1ns / 1ps

module bmcd_cell #(
    parameter int COLOR_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bmcd_pkg::t_bcast i_bc,
    input  logic           i_prev_valid,
    input  logic           i_clear,
    input  bmcd_pkg::t_scan  i_scan,
    output logic           o_valid,
    output logic           o_match,
    output bmcd_pkg::t_scan  o_scan
);
    import bmcd_pkg::*;

    logic                  r_valid;
    logic [COLOR_BITS-1:0] r_color;
    logic [CNT_W-1:0]      r_cnt;
    t_scan                 r_scan;
    logic                  alloc;
    logic                  take;

    assign o_match = r_valid && (r_color == i_bc.color[COLOR_BITS-1:0]);
    // The first empty cell of the chain takes a colour that no cell holds.
    assign alloc   = i_bc.en && !i_bc.hit && !r_valid && i_prev_valid;
    assign take    = r_valid && (r_cnt > i_scan.cnt);
    assign o_valid = r_valid;
    assign o_scan  = r_scan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_clear) begin
            r_valid <= 1'b0;
        end else if (alloc) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (alloc) begin
            r_color <= i_bc.color[COLOR_BITS-1:0];
            r_cnt   <= CNT_ONE;
        end else if (i_bc.en && o_match && (r_cnt != CNT_MAX)) begin
            r_cnt <= r_cnt + CNT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan.go <= 1'b0;
        end else begin
            r_scan.go <= i_scan.go;
        end
        if (take) begin
            r_scan.cnt   <= r_cnt;
            r_scan.color <= COLOR_W'(r_color);
        end else begin
            r_scan.cnt   <= i_scan.cnt;
            r_scan.color <= i_scan.color;
        end
    end

endmodule

### hdl/block_mode_color_downscaler.sv
`timescale 1ns / 1ps
// Pixels are taken one per cycle while no search runs, and a last pixel only
// while no result is held; each is matched against all table cells at once.
// The transaction marked last starts a search that walks the cell chain, one
// cell a cycle; its result is registered at the output as it leaves the last cell.
// No pixel is taken while it runs. Synchronous active-low reset empties the table.

module block_mode_color_downscaler #(
    parameter int MAX_COLORS = 64,
    parameter int COLOR_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_pixel_color,
    input  logic        i_last_in_block,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_mode_color,
    output logic [6:0]  o_mode_count,
    output logic [6:0]  o_distinct_colors,
    output logic        o_table_overflow
);
    import bmcd_pkg::*;

    localparam int UW = $clog2(MAX_COLORS + 1);

    logic [UW-1:0]         r_used;
    logic [UW-1:0]         n_used;
    logic                  r_ovf;
    logic                  r_busy;
    logic                  r_scan_go;
    logic [CNT_W-1:0]      r_res_distinct;
    logic                  r_res_ovf;
    logic                  r_out_valid;
    logic [COLOR_W-1:0]    r_out_color;
    logic [CNT_W-1:0]      r_out_cnt;
    logic [CNT_W-1:0]      r_out_distinct;
    logic                  r_out_ovf;

    logic                  in_acc;
    logic                  hit;
    logic                  full;
    logic                  scan_done;
    t_bcast                bc;
    logic [MAX_COLORS:0]   cell_valid;
    logic [MAX_COLORS-1:0] match_vec;
    t_scan                 scan_chain [MAX_COLORS+1];

    assign in_acc    = i_valid && o_ready;
    assign o_ready   = !r_busy && !(i_last_in_block && r_out_valid);
    assign hit       = |match_vec;
    assign full      = (r_used == UW'(MAX_COLORS));
    assign n_used    = (!hit && !full) ? r_used + UW'(1) : r_used;
    assign scan_done = scan_chain[MAX_COLORS].go;

    assign bc.en    = in_acc;
    assign bc.color = COLOR_W'(i_pixel_color[COLOR_BITS-1:0]);
    assign bc.hit   = hit;

    assign cell_valid[0]       = 1'b1;
    assign scan_chain[0].go    = r_scan_go;
    assign scan_chain[0].cnt   = CNT_NONE;
    assign scan_chain[0].color = COLOR_NONE;

    for (genvar k = 0; k < MAX_COLORS; k++) begin : g_cell
        bmcd_cell #(
            .COLOR_BITS(COLOR_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_bc        (bc),
            .i_prev_valid(cell_valid[k]),
            .i_clear     (scan_done),
            .i_scan      (scan_chain[k]),
            .o_valid     (cell_valid[k+1]),
            .o_match     (match_vec[k]),
            .o_scan      (scan_chain[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_ovf     <= 1'b0;
            r_busy    <= 1'b0;
            r_scan_go <= 1'b0;
        end else begin
            r_scan_go <= in_acc && i_last_in_block;
            if (in_acc && i_last_in_block) begin
                r_used <= '0;
                r_ovf  <= 1'b0;
                r_busy <= 1'b1;
            end else if (in_acc) begin
                r_used <= n_used;
                r_ovf  <= r_ovf || (!hit && full);
            end
            if (scan_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_last_in_block) begin
            r_res_distinct <= (32'(n_used) > 32'(CNT_MAX)) ? CNT_MAX : CNT_W'(n_used);
            r_res_ovf      <= r_ovf || (!hit && full);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (scan_done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_done) begin
            r_out_color    <= scan_chain[MAX_COLORS].color;
            r_out_cnt      <= scan_chain[MAX_COLORS].cnt;
            r_out_distinct <= r_res_distinct;
            r_out_ovf      <= r_res_ovf;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_mode_color      = r_out_color;
    assign o_mode_count      = r_out_cnt;
    assign o_distinct_colors = r_out_distinct;
    assign o_table_overflow  = r_out_ovf;

`ifndef ASSERT_OFF
    a_one_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(match_vec))
        else $error("colour held by more than one cell");

    a_fill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> ($countones(cell_valid) == 32'(r_used) + 32'd1))
        else $error("occupied cells disagree with fill count");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_done |-> !r_out_valid)
        else $error("search finished while a result was still held");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last_in_block) |=> (r_busy && r_scan_go))
        else $error("last pixel did not start the search");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import bmcd_pkg::*;

    localparam int MAX_COLORS   = 64;
    localparam int ITEMS_TARGET = 1050;
    localparam int IDLE_LIMIT   = 1000;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [CNT_W-1:0]   count;
        logic [CNT_W-1:0]   distinct;
        logic               overflow;
    } block_mode_t;

    // Keeps its own colour table and the queue of block results still owed by the block.
    class mode_scoreboard;
        logic [COLOR_W-1:0] hue_color [MAX_COLORS];
        logic [CNT_W-1:0]   hue_count [MAX_COLORS];
        int                 hues_used;
        bit                 hues_dropped;
        block_mode_t        expected_modes [$];
        int                 mismatches;

        function new();
            hues_used    = 0;
            hues_dropped = 0;
            mismatches   = 0;
        endfunction

        function int pending();
            return expected_modes.size();
        endfunction

        function void note_pixel(logic [COLOR_W-1:0] color, logic last);
            bit          found;
            int          best;
            block_mode_t mode;
            found = 0;
            for (int k = 0; k < hues_used; k++) begin
                if (!found && hue_color[k] == color) begin
                    found = 1;
                    if (hue_count[k] != CNT_MAX) hue_count[k] = hue_count[k] + 1'b1;
                end
            end
            if (!found) begin
                if (hues_used < MAX_COLORS) begin
                    hue_color[hues_used] = color;
                    hue_count[hues_used] = CNT_ONE;
                    hues_used++;
                end else begin
                    hues_dropped = 1;
                end
            end
            if (last) begin
                // Strict comparison, so the colour that entered the table first wins a tie.
                best       = -1;
                mode.color = COLOR_NONE;
                for (int k = 0; k < hues_used; k++) begin
                    if (int'(hue_count[k]) > best) begin
                        best       = int'(hue_count[k]);
                        mode.color = hue_color[k];
                    end
                end
                mode.count    = (best < 0) ? CNT_NONE : CNT_W'(best);
                mode.distinct = (hues_used > int'(CNT_MAX)) ? CNT_MAX : CNT_W'(hues_used);
                mode.overflow = hues_dropped;
                expected_modes.push_back(mode);
                hues_used    = 0;
                hues_dropped = 0;
            end
        endfunction

        task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
            $display("%0t: %s mismatch, got %0h, expected %0h", $time, field, got, want);
            mismatches++;
        endtask

        task check_result(block_mode_t got);
            block_mode_t want;
            if (expected_modes.size() == 0) begin
                report_mismatch("unexpected result", got.color, '0);
            end else begin
                want = expected_modes.pop_front();
                if (got.color != want.color)
                    report_mismatch("mode_color", got.color, want.color);
                if (got.count != want.count)
                    report_mismatch("mode_count", 32'(got.count), 32'(want.count));
                if (got.distinct != want.distinct)
                    report_mismatch("distinct_colors", 32'(got.distinct), 32'(want.distinct));
                if (got.overflow != want.overflow)
                    report_mismatch("table_overflow", 32'(got.overflow), 32'(want.overflow));
            end
        endtask
    endclass

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_valid         = 1'b0;
    logic               o_ready;
    logic [COLOR_W-1:0] i_pixel_color   = '0;
    logic               i_last_in_block = 1'b0;
    logic               o_valid;
    logic               i_ready         = 1'b0;
    logic [COLOR_W-1:0] o_mode_color;
    logic [CNT_W-1:0]   o_mode_count;
    logic [CNT_W-1:0]   o_distinct_colors;
    logic               o_table_overflow;

    mode_scoreboard sb;
    bit             steady      = 0;
    int             pixels_sent = 0;
    int             idle_cycles = 0;

    block_mode_color_downscaler #(
        .MAX_COLORS (MAX_COLORS),
        .COLOR_BITS (COLOR_W)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_pixel_color     (i_pixel_color),
        .i_last_in_block   (i_last_in_block),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_mode_color      (o_mode_color),
        .o_mode_count      (o_mode_count),
        .o_distinct_colors (o_distinct_colors),
        .o_table_overflow  (o_table_overflow)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                sb.note_pixel(i_pixel_color, i_last_in_block);
            end
            if (o_valid && i_ready) begin
                sb.check_result({o_mode_color, o_mode_count, o_distinct_colors,
                                 o_table_overflow});
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("block_mode_color_downscaler test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: either ready ahead of the result, or a stall once the result is up.
    initial begin
        int stall;
        forever begin
            stall = steady ? 0 : $urandom_range(0, 3);
            if (stall == 0) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b0;
                do @(posedge i_clk); while (!o_valid);
                repeat (stall - 1) @(posedge i_clk);
                i_ready <= 1'b1;
            end
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    function automatic logic [COLOR_W-1:0] random_color();
        if ($urandom_range(0, 7) == 0) begin
            return $urandom_range(0, 1) ? '1 : '0;
        end
        return $urandom();
    endfunction

    task automatic send_pixel(input logic [COLOR_W-1:0] color, input logic last);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_pixel_color   <= color;
        i_last_in_block <= last;
        do @(posedge i_clk); while (!o_ready);
        pixels_sent++;
    endtask

    // With sweep set, every palette colour is sent once in order before the random picks.
    task automatic send_block(input int n_pix, input int n_hues, input bit sweep);
        logic [COLOR_W-1:0] palette [$];
        for (int i = 0; i < n_hues; i++) palette.push_back(random_color());
        for (int i = 0; i < n_pix; i++) begin
            send_pixel((sweep && i < n_hues) ? palette[i]
                                             : palette[$urandom_range(0, n_hues - 1)],
                       i == n_pix - 1);
        end
    endtask

    // The first edge lets the monitor note the final transaction before the queue is read.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        int blk;
        int kind;
        int hues;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-pixel blocks at both colour extremes.
        send_pixel(32'h0000_0000, 1'b1);
        send_pixel(32'hFFFF_FFFF, 1'b1);
        // Equal counts: the colour seen first must win.
        send_pixel(32'h8000_0001, 1'b0);
        send_pixel(32'h7FFF_FFFE, 1'b0);
        send_pixel(32'h7FFF_FFFE, 1'b0);
        send_pixel(32'h8000_0001, 1'b1);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'h5555_AAAA, 1'b1);
        // A later colour overtakes the first one.
        send_pixel(32'hAAAA_5555, 1'b0);
        send_pixel(32'h1234_5678, 1'b0);
        send_pixel(32'h1234_5678, 1'b0);
        send_pixel(32'h1234_5678, 1'b1);
        wait_for_results();

        blk = 0;
        while (pixels_sent < ITEMS_TARGET) begin
            steady = ($urandom_range(0, 5) == 0);
            kind   = $urandom_range(0, 29);
            if (kind == 6) wait_for_results();
            if (blk == 12 || kind == 0) begin
                // One colour long enough to saturate its count.
                send_block($urandom_range(128, 140), 1, 1'b0);
            end else if (blk == 5 || kind <= 2) begin
                // Around the table size: nearly full, exactly full, and dropped colours.
                hues = $urandom_range(60, 80);
                send_block(hues + $urandom_range(0, 12), hues, 1'b1);
            end else if (kind <= 5) begin
                hues = $urandom_range(1, 6);
                send_block(hues, hues, 1'b1);
            end else begin
                send_block($urandom_range(1, 16), $urandom_range(1, 4), 1'b0);
            end
            blk++;
        end

        steady = 0;
        wait_for_results();
        repeat (MAX_COLORS + 8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("block_mode_color_downscaler test passed");
        end else begin
            $display("block_mode_color_downscaler test failed");
        end
        $finish;
    end

endmodule
